// ===== rtl/core/cilc_pkg.sv =====
// ----------------------------------------------------------------------------
// cilc_pkg
// Shared types, constants, issuer table and digit helpers of the card number
// classifier.
// ----------------------------------------------------------------------------
package cilc_pkg;

  localparam int unsigned LEN_W       = 6;
  localparam int unsigned LEAD_W      = 4;
  localparam int unsigned ROM_ROWS    = 64;
  localparam int unsigned ROM_IDX_W   = 6;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned DEC_BASE    = 10;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;
  localparam logic [3:0] DIGIT_MAX  = 4'd9;

  typedef struct packed {
    logic [LEAD_W-1:0] digits;
    logic [31:0]       lo;
    logic [31:0]       hi;
    logic [LEN_W-1:0]  minlen;
    logic [LEN_W-1:0]  maxlen;
    logic              luhn_req;
    logic              active;
  } iin_row_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [LEAD_W-1:0] lead;
    logic              luhn_ok;
  } meta_t;

  function automatic iin_row_t mk_row(input int unsigned dg, input int unsigned lo,
                                      input int unsigned hi, input int unsigned mn,
                                      input int unsigned mx, input int unsigned rq,
                                      input int unsigned ac);
    iin_row_t r;
    r.digits   = LEAD_W'(dg);
    r.lo       = 32'(lo);
    r.hi       = 32'(hi);
    r.minlen   = LEN_W'(mn);
    r.maxlen   = LEN_W'(mx);
    r.luhn_req = 1'(rq);
    r.active   = 1'(ac);
    return r;
  endfunction

  function automatic iin_row_t rom_row(input logic [ROM_IDX_W-1:0] idx);
    iin_row_t r;
    unique case (idx)
      6'd0:  r = mk_row(2, 34, 34, 15, 15, 1, 1);
      6'd1:  r = mk_row(2, 37, 37, 15, 15, 1, 1);
      6'd2:  r = mk_row(4, 5610, 5610, 16, 16, 1, 0);
      6'd3:  r = mk_row(6, 560221, 560225, 16, 16, 1, 0);
      6'd4:  r = mk_row(2, 62, 62, 16, 19, 0, 1);
      6'd5:  r = mk_row(2, 88, 88, 16, 19, 0, 1);
      6'd6:  r = mk_row(3, 300, 305, 14, 14, 1, 1);
      6'd7:  r = mk_row(4, 2014, 2014, 15, 15, 0, 0);
      6'd8:  r = mk_row(4, 2149, 2149, 15, 15, 0, 0);
      6'd9:  r = mk_row(3, 300, 305, 14, 14, 1, 1);
      6'd10: r = mk_row(3, 309, 309, 14, 14, 1, 1);
      6'd11: r = mk_row(2, 36, 36, 14, 14, 1, 1);
      6'd12: r = mk_row(2, 38, 39, 14, 14, 1, 1);
      6'd13: r = mk_row(2, 54, 55, 16, 16, 1, 1);
      6'd14: r = mk_row(4, 6011, 6011, 16, 16, 1, 1);
      6'd15: r = mk_row(6, 622126, 622925, 16, 16, 1, 1);
      6'd16: r = mk_row(3, 644, 649, 16, 16, 1, 1);
      6'd17: r = mk_row(2, 65, 65, 16, 16, 1, 1);
      6'd18: r = mk_row(3, 637, 639, 16, 16, 1, 1);
      6'd19: r = mk_row(4, 3528, 3589, 16, 16, 1, 1);
      6'd20: r = mk_row(4, 6304, 6304, 16, 19, 1, 1);
      6'd21: r = mk_row(4, 6706, 6706, 16, 19, 1, 1);
      6'd22: r = mk_row(4, 6771, 6771, 16, 19, 1, 1);
      6'd23: r = mk_row(4, 6709, 6709, 16, 19, 1, 1);
      6'd24: r = mk_row(4, 5018, 5018, 12, 19, 1, 1);
      6'd25: r = mk_row(4, 5020, 5020, 12, 19, 1, 1);
      6'd26: r = mk_row(4, 5038, 5038, 12, 19, 1, 1);
      6'd27: r = mk_row(4, 5612, 5612, 12, 19, 1, 1);
      6'd28: r = mk_row(4, 5893, 5893, 12, 19, 1, 1);
      6'd29: r = mk_row(4, 6304, 6304, 12, 19, 1, 1);
      6'd30: r = mk_row(4, 6759, 6759, 12, 19, 1, 1);
      6'd31: r = mk_row(4, 6761, 6763, 12, 19, 1, 1);
      6'd32: r = mk_row(4, 6390, 6390, 12, 19, 1, 1);
      6'd33: r = mk_row(4, 5019, 5019, 16, 16, 1, 1);
      6'd34: r = mk_row(2, 50, 55, 16, 16, 1, 1);
      6'd35: r = mk_row(4, 6334, 6334, 16, 19, 1, 0);
      6'd36: r = mk_row(4, 6767, 6767, 16, 19, 1, 0);
      6'd37: r = mk_row(4, 4903, 4903, 16, 19, 1, 0);
      6'd38: r = mk_row(4, 4905, 4905, 16, 19, 1, 0);
      6'd39: r = mk_row(4, 4911, 4911, 16, 19, 1, 0);
      6'd40: r = mk_row(4, 4936, 4936, 16, 19, 1, 0);
      6'd41: r = mk_row(6, 564182, 564182, 16, 19, 1, 0);
      6'd42: r = mk_row(6, 633110, 633110, 16, 19, 1, 0);
      6'd43: r = mk_row(4, 6333, 6759, 16, 19, 1, 0);
      6'd44: r = mk_row(1, 4, 4, 13, 16, 1, 1);
      6'd45: r = mk_row(4, 4026, 4026, 16, 16, 1, 1);
      6'd46: r = mk_row(6, 417500, 417500, 16, 16, 1, 1);
      6'd47: r = mk_row(4, 4405, 4405, 16, 16, 1, 1);
      6'd48: r = mk_row(4, 4508, 4508, 16, 16, 1, 1);
      6'd49: r = mk_row(4, 4844, 4844, 16, 16, 1, 1);
      6'd50: r = mk_row(4, 4913, 4913, 16, 16, 1, 1);
      6'd51: r = mk_row(4, 4917, 4917, 16, 16, 1, 1);
      default: r = mk_row(0, 0, 0, 0, 0, 0, 0);
    endcase
    return r;
  endfunction

  function automatic logic [3:0] add_mod10(input logic [3:0] a, input logic [3:0] b);
    logic [4:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= 5'(DEC_BASE)) ? 4'(s - 5'(DEC_BASE)) : s[3:0];
  endfunction

  function automatic logic [3:0] luhn_double(input logic [3:0] d);
    logic [4:0] dd;
    dd = {d, 1'b0};
    return (dd > {1'b0, DIGIT_MAX}) ? 4'(dd - {1'b0, DIGIT_MAX}) : dd[3:0];
  endfunction

endpackage

// ===== rtl/core/cilc_if.sv =====
// ----------------------------------------------------------------------------
// cilc_in_if / cilc_out_if
// Valid/ready channels for character beats and classification results.
// ----------------------------------------------------------------------------
interface cilc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface cilc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] match_mask;
  logic        found;
  logic        luhn_ok;
  logic [5:0]  length;

  modport source (output valid, output match_mask, output found, output luhn_ok,
                  output length, input ready);
  modport sink   (input valid, input match_mask, input found, input luhn_ok,
                  input length, output ready);
endinterface

// ===== rtl/core/card_number_iin_luhn_classifier_top.sv =====
// ----------------------------------------------------------------------------
// card_number_iin_luhn_classifier_top
// Card number classifier: issuer prefix range lookup with a mod 10 check.
// ----------------------------------------------------------------------------
// Send a card number as one ASCII character per input beat and mark the final
// character with last. A beat is taken while the queue has room, so numbers
// stream back to back at one character per clock until it fills. Once the last
// beat has passed the queue and the output register, the result beat shows
// the mask of matching issuer rows, found, luhn_ok and the saturated length.
// The table compare runs on all rows at once from a two-entry queue, so a
// stalled result holds the input only once that queue is full. Characters
// past MAX_CHARS are dropped and fail the check.
module card_number_iin_luhn_classifier_top #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned MAX_CHARS     = 63,
  parameter int unsigned PREFIX_DIGITS = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  cilc_in_if.sink    in_ch,
  cilc_out_if.source out_ch
);
  import cilc_pkg::*;

  localparam int unsigned VAL_W  = $clog2(DEC_BASE ** PREFIX_DIGITS);
  localparam int unsigned VALS_W = PREFIX_DIGITS * VAL_W;
  localparam int unsigned META_W = $bits(meta_t);
  localparam int unsigned Q_W    = VALS_W + META_W;

  logic              push_valid;
  logic              push_ready;
  logic [VALS_W-1:0] push_vals;
  meta_t             push_meta;
  logic              head_valid;
  logic              head_pop;
  logic [Q_W-1:0]    head_data;
  meta_t             head_meta;

  cilc_front #(
    .MAX_CHARS     (MAX_CHARS),
    .PREFIX_DIGITS (PREFIX_DIGITS),
    .VAL_W         (VAL_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_vals  (push_vals),
    .push_meta  (push_meta)
  );

  cilc_fifo #(
    .W     (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_vals, push_meta}),
    .head_valid (head_valid),
    .pop        (head_pop),
    .head_data  (head_data)
  );

  assign head_meta = head_data[META_W-1:0];

  cilc_match #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .PREFIX_DIGITS (PREFIX_DIGITS),
    .VAL_W         (VAL_W)
  ) u_match (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_vals  (head_data[Q_W-1:META_W]),
    .head_meta  (head_meta),
    .head_pop   (head_pop),
    .out_ch     (out_ch)
  );

  a_no_out_after_reset: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result beat right after reset");

  a_found_is_any: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.found == (out_ch.match_mask != 64'd0)))
    else $error("found disagrees with match mask");

  a_luhn_needs_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.luhn_ok) |-> (out_ch.length != 6'd0))
    else $error("check passed on an empty number");

  a_mask_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.match_mask >> TABLE_ENTRIES) == 64'd0))
    else $error("match bit beyond table");

endmodule

// ===== rtl/core/cilc_front.sv =====
// ----------------------------------------------------------------------------
// cilc_front
// Accumulates one card number a character beat at a time: length, leading
// prefix values, bad character flag and both Luhn parity sums.
// ----------------------------------------------------------------------------
module cilc_front #(
  parameter int unsigned MAX_CHARS     = 63,
  parameter int unsigned PREFIX_DIGITS = 6,
  parameter int unsigned VAL_W         = 20
) (
  input  logic                             clk,
  input  logic                             rst_n,
  cilc_in_if.sink                          in_ch,
  output logic                             push_valid,
  input  logic                             push_ready,
  output logic [PREFIX_DIGITS*VAL_W-1:0]   push_vals,
  output cilc_pkg::meta_t                  push_meta
);
  import cilc_pkg::*;

  localparam int unsigned IDX_W = (PREFIX_DIGITS > 1) ? $clog2(PREFIX_DIGITS) : 1;

  logic [LEN_W-1:0]  cnt_r,  cnt_nxt;
  logic [LEAD_W-1:0] lead_r, lead_nxt;
  logic [3:0]        even_r, even_nxt;
  logic [3:0]        odd_r,  odd_nxt;
  logic              nd_r,   nd_nxt;
  logic [VAL_W-1:0]  pv_r   [PREFIX_DIGITS];
  logic [VAL_W-1:0]  pv_nxt [PREFIX_DIGITS];

  logic             acc;
  logic             is_dig;
  logic [3:0]       dig;
  logic [3:0]       dig2;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] prev_idx;
  logic [VAL_W-1:0] prev_val;
  logic [3:0]       total;

  assign in_ch.ready = push_ready;
  assign acc         = in_ch.valid && push_ready;
  assign is_dig      = (in_ch.char_code >= ASCII_ZERO) && (in_ch.char_code <= ASCII_NINE);
  assign dig         = 4'(in_ch.char_code - ASCII_ZERO);
  assign dig2        = luhn_double(dig);
  assign wr_idx      = cnt_r[IDX_W-1:0];
  assign prev_idx    = IDX_W'(cnt_r - LEN_W'(1));
  assign prev_val    = (cnt_r == '0) ? '0 : pv_r[prev_idx];

  always_comb begin
    cnt_nxt  = cnt_r;
    lead_nxt = lead_r;
    even_nxt = even_r;
    odd_nxt  = odd_r;
    nd_nxt   = nd_r;
    pv_nxt   = pv_r;
    if (acc) begin
      if (cnt_r >= LEN_W'(MAX_CHARS)) begin
        nd_nxt = 1'b1;
      end else begin
        if (is_dig) begin
          if (!cnt_r[0]) begin
            even_nxt = add_mod10(even_r, dig2);
            odd_nxt  = add_mod10(odd_r, dig);
          end else begin
            even_nxt = add_mod10(even_r, dig);
            odd_nxt  = add_mod10(odd_r, dig2);
          end
          if ((cnt_r < LEN_W'(PREFIX_DIGITS)) && (cnt_r == LEN_W'(lead_r))) begin
            pv_nxt[wr_idx] = VAL_W'(prev_val * VAL_W'(DEC_BASE)) + VAL_W'(dig);
            lead_nxt       = lead_r + LEAD_W'(1);
          end
        end else begin
          nd_nxt = 1'b1;
        end
        cnt_nxt = cnt_r + LEN_W'(1);
      end
    end
  end

  assign total             = cnt_nxt[0] ? odd_nxt : even_nxt;
  assign push_valid        = in_ch.valid && in_ch.last;
  assign push_meta.len     = cnt_nxt;
  assign push_meta.lead    = lead_nxt;
  assign push_meta.luhn_ok = !nd_nxt && (total == 4'd0);

  for (genvar k = 0; k < PREFIX_DIGITS; k++) begin : g_flat
    assign push_vals[k*VAL_W +: VAL_W] = pv_nxt[k];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      lead_r <= '0;
      even_r <= '0;
      odd_r  <= '0;
      nd_r   <= 1'b0;
    end else if (acc && in_ch.last) begin
      cnt_r  <= '0;
      lead_r <= '0;
      even_r <= '0;
      odd_r  <= '0;
      nd_r   <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      lead_r <= lead_nxt;
      even_r <= even_nxt;
      odd_r  <= odd_nxt;
      nd_r   <= nd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pv_r <= pv_nxt;
  end

endmodule

// ===== rtl/core/cilc_fifo.sv =====
// ----------------------------------------------------------------------------
// cilc_fifo
// Small register queue that decouples number accumulation from table lookup.
// ----------------------------------------------------------------------------
module cilc_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         head_valid,
  input  logic         pop,
  output logic [W-1:0] head_data
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r,  cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
    end
    cnt_nxt = cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/cilc_match.sv =====
// ----------------------------------------------------------------------------
// cilc_match
// Compares a finished number against every issuer row in parallel and holds
// the result beat in the output register.
// ----------------------------------------------------------------------------
module cilc_match #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned PREFIX_DIGITS = 6,
  parameter int unsigned VAL_W         = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           head_valid,
  input  logic [PREFIX_DIGITS*VAL_W-1:0] head_vals,
  input  cilc_pkg::meta_t                head_meta,
  output logic                           head_pop,
  cilc_out_if.source                     out_ch
);
  import cilc_pkg::*;

  localparam int unsigned IDX_W = (PREFIX_DIGITS > 1) ? $clog2(PREFIX_DIGITS) : 1;

  logic        out_valid_r;
  logic [63:0] mask_r,  mask_nxt;
  logic        luhn_r;
  logic [5:0]  len_r;
  logic        found_r;
  logic        load;

  assign load     = head_valid && (!out_valid_r || out_ch.ready);
  assign head_pop = load;

  always_comb begin
    iin_row_t         row;
    logic             ok;
    logic [IDX_W-1:0] sel;
    logic [VAL_W-1:0] v;
    mask_nxt = '0;
    for (int i = 0; i < ROM_ROWS; i++) begin
      row = rom_row(ROM_IDX_W'(i));
      ok  = (i < TABLE_ENTRIES) && (row.digits != '0) &&
            (row.digits <= LEAD_W'(PREFIX_DIGITS)) && (row.digits <= head_meta.lead);
      sel = ok ? IDX_W'(row.digits - LEAD_W'(1)) : '0;
      v   = head_vals[sel*VAL_W +: VAL_W];
      mask_nxt[i] = ok && (32'(v) >= row.lo) && (32'(v) <= row.hi) &&
                    (head_meta.len >= row.minlen) && (head_meta.len <= row.maxlen) &&
                    (!row.luhn_req || head_meta.luhn_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mask_r  <= mask_nxt;
      found_r <= |mask_nxt;
      luhn_r  <= head_meta.luhn_ok;
      len_r   <= head_meta.len;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.match_mask = mask_r;
  assign out_ch.found      = found_r;
  assign out_ch.luhn_ok    = luhn_r;
  assign out_ch.length     = len_r;

endmodule
